>>> rtl/rtp_pkg.sv
// Shared types and constants for the rectangle tree packer.
// Used by rtp_split and rect_tree_packer_unit; no dependencies.
package rtp_pkg;

  localparam int MaxFree  = 128;
  localparam int IdxW     = $clog2(MaxFree);
  localparam int CntW     = $clog2(MaxFree + 1);
  localparam int CoordW   = 16;
  localparam int AreaW    = 32;
  localparam int EntryW   = 4 * CoordW;
  localparam int CfgIdxW  = 1;

  localparam logic [CoordW-1:0] BinResetSize = CoordW'(1024);

  localparam logic OpInsert = 1'b0;
  localparam logic OpClear  = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgBinWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgBinHeight = CfgIdxW'(1);

  typedef enum logic [1:0] {
    StatPlaced = 2'd0,
    StatNoFit  = 2'd1,
    StatFull   = 2'd2,
    StatClear  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StClear,
    StScan,
    StShift,
    StWriteA,
    StWriteB
  } state_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
  } rect_t;

endpackage

>>> rtl/rect_tree_packer_unit.sv
// Rectangle packer, a guillotine tree kept as an ordered list of free rectangles
// in one RAM. Depends on rtp_pkg, rtp_ram and rtp_split.
//
// One op at a time: start is taken while busy is low, and one result word is
// shown on done_o for a single cycle; it cannot be held off. A clear passes
// through StClear alone and its word follows in the next. An insert reads the
// free list one entry a cycle until the first fit, or to the last entry when
// nothing fits; a fit with a full list ends the op. Otherwise it then moves the
// entries behind the hit up by one slot at one per cycle through the same RAM
// port pair, then writes the two children in StWriteA and StWriteB, with the
// word in the cycle after. Reset is followed by the busy StInit state, which
// writes the bin-sized entry. Bin sizes take effect at the next clear.
module rect_tree_packer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rtp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rtp_pkg::CoordW-1:0]     cfg_wdata_i,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode_i,
  input  logic [rtp_pkg::CoordW-1:0]     rect_width_i,
  input  logic [rtp_pkg::CoordW-1:0]     rect_height_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [rtp_pkg::CoordW-1:0]     place_x_o,
  output logic [rtp_pkg::CoordW-1:0]     place_y_o,
  output logic [rtp_pkg::AreaW-1:0]      area_used_o
);

  rtp_pkg::state_e state_q, state_d;

  logic [rtp_pkg::CoordW-1:0] bin_w_q, bin_h_q;
  logic [rtp_pkg::CoordW-1:0] req_w_q, req_h_q;
  logic                       req_op_q;
  logic [rtp_pkg::AreaW-1:0]  prod_q;
  logic [rtp_pkg::AreaW-1:0]  area_q, area_d;
  logic [rtp_pkg::CntW-1:0]   count_q, count_d;
  logic [rtp_pkg::CntW-1:0]   iss_q, iss_d;
  logic [rtp_pkg::CntW-1:0]   src_q, src_d;
  logic                       chk_vld_q, chk_vld_d;
  logic [rtp_pkg::IdxW-1:0]   chk_idx_q, chk_idx_d;
  logic                       sh_vld_q, sh_vld_d;
  logic [rtp_pkg::IdxW-1:0]   sh_dst_q, sh_dst_d;
  logic [rtp_pkg::IdxW-1:0]   hit_q, hit_d;
  rtp_pkg::rect_t             hit_rect_q, hit_rect_d;

  logic                       done_d;
  rtp_pkg::status_e           status_q, status_d;
  logic [rtp_pkg::CoordW-1:0] px_q, px_d, py_q, py_d;

  logic                       mem_we;
  logic [rtp_pkg::IdxW-1:0]   mem_waddr, mem_raddr;
  rtp_pkg::rect_t             mem_wdata, rd_rect;
  logic [rtp_pkg::EntryW-1:0] rd_data;

  rtp_pkg::rect_t             child_a, child_b;

  logic accept, fit, last_chk, scan_issue, shift_issue;
  logic [rtp_pkg::CntW-1:0] hit_next;

  assign accept = start && !busy;
  assign busy   = (state_q != rtp_pkg::StIdle);
  assign rd_rect = rd_data;

  assign fit      = (req_w_q <= rd_rect.w) && (req_h_q <= rd_rect.h);
  assign last_chk = (rtp_pkg::CntW'(chk_idx_q) == count_q - rtp_pkg::CntW'(1));
  assign hit_next = rtp_pkg::CntW'(hit_q) + rtp_pkg::CntW'(1);

  assign scan_issue  = (iss_q < count_q) && !(chk_vld_q && fit);
  assign shift_issue = (src_q >= hit_next);

  rtp_ram #(
    .Width(rtp_pkg::EntryW),
    .Depth(rtp_pkg::MaxFree)
  ) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(rd_data)
  );

  rtp_split u_split (
    .free_i       (hit_rect_q),
    .rect_width_i (req_w_q),
    .rect_height_i(req_h_q),
    .child_a_o    (child_a),
    .child_b_o    (child_b)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rtp_pkg::StInit: state_d = rtp_pkg::StIdle;
      rtp_pkg::StIdle: begin
        if (accept) begin
          state_d = (opcode_i == rtp_pkg::OpClear) ? rtp_pkg::StClear : rtp_pkg::StScan;
        end
      end
      rtp_pkg::StClear: state_d = rtp_pkg::StIdle;
      rtp_pkg::StScan: begin
        if (chk_vld_q && fit) begin
          state_d = (count_q >= rtp_pkg::CntW'(rtp_pkg::MaxFree)) ? rtp_pkg::StIdle
                                                                   : rtp_pkg::StShift;
        end else if (chk_vld_q && last_chk) begin
          state_d = rtp_pkg::StIdle;
        end
      end
      rtp_pkg::StShift: begin
        if (!shift_issue && !sh_vld_q) begin
          state_d = rtp_pkg::StWriteA;
        end
      end
      rtp_pkg::StWriteA: state_d = rtp_pkg::StWriteB;
      rtp_pkg::StWriteB: state_d = rtp_pkg::StIdle;
      default:           state_d = rtp_pkg::StIdle;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;
    area_d     = area_q;
    count_d    = count_q;
    iss_d      = iss_q;
    src_d      = src_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    sh_vld_d   = 1'b0;
    sh_dst_d   = sh_dst_q;
    hit_d      = hit_q;
    hit_rect_d = hit_rect_q;
    done_d     = 1'b0;
    status_d   = status_q;
    px_d       = px_q;
    py_d       = py_q;
    case (state_q)
      rtp_pkg::StInit: begin
        mem_we    = 1'b1;
        mem_wdata = '{x: '0, y: '0, w: rtp_pkg::BinResetSize, h: rtp_pkg::BinResetSize};
      end
      rtp_pkg::StIdle: begin
        iss_d = '0;
      end
      rtp_pkg::StClear: begin
        mem_we   = 1'b1;
        mem_wdata = '{x: '0, y: '0, w: bin_w_q, h: bin_h_q};
        count_d  = rtp_pkg::CntW'(1);
        area_d   = '0;
        done_d   = 1'b1;
        status_d = rtp_pkg::StatClear;
        px_d     = '0;
        py_d     = '0;
      end
      rtp_pkg::StScan: begin
        mem_raddr = iss_q[rtp_pkg::IdxW-1:0];
        if (scan_issue) begin
          chk_vld_d = 1'b1;
          chk_idx_d = iss_q[rtp_pkg::IdxW-1:0];
          iss_d     = iss_q + rtp_pkg::CntW'(1);
        end
        if (chk_vld_q && fit) begin
          hit_d      = chk_idx_q;
          hit_rect_d = rd_rect;
          src_d      = count_q - rtp_pkg::CntW'(1);
          chk_vld_d  = 1'b0;
          if (count_q >= rtp_pkg::CntW'(rtp_pkg::MaxFree)) begin
            done_d   = 1'b1;
            status_d = rtp_pkg::StatFull;
            px_d     = '0;
            py_d     = '0;
          end
        end else if (chk_vld_q && last_chk) begin
          done_d   = 1'b1;
          status_d = rtp_pkg::StatNoFit;
          px_d     = '0;
          py_d     = '0;
        end
      end
      rtp_pkg::StShift: begin
        // reads walk down, and each word read lands one slot up
        mem_raddr = src_q[rtp_pkg::IdxW-1:0];
        if (shift_issue) begin
          sh_vld_d = 1'b1;
          sh_dst_d = src_q[rtp_pkg::IdxW-1:0] + rtp_pkg::IdxW'(1);
          src_d    = src_q - rtp_pkg::CntW'(1);
        end
        if (sh_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = sh_dst_q;
          mem_wdata = rd_rect;
        end
      end
      rtp_pkg::StWriteA: begin
        mem_we    = 1'b1;
        mem_waddr = hit_q;
        mem_wdata = child_a;
      end
      rtp_pkg::StWriteB: begin
        mem_we    = 1'b1;
        mem_waddr = hit_q + rtp_pkg::IdxW'(1);
        mem_wdata = child_b;
        count_d   = count_q + rtp_pkg::CntW'(1);
        area_d    = area_q + prod_q;
        done_d    = 1'b1;
        status_d  = rtp_pkg::StatPlaced;
        px_d      = hit_rect_q.x;
        py_d      = hit_rect_q.y;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rtp_pkg::StInit;
      bin_w_q   <= rtp_pkg::BinResetSize;
      bin_h_q   <= rtp_pkg::BinResetSize;
      area_q    <= '0;
      count_q   <= rtp_pkg::CntW'(1);
      chk_vld_q <= 1'b0;
      sh_vld_q  <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      state_q   <= state_d;
      area_q    <= area_d;
      count_q   <= count_d;
      chk_vld_q <= chk_vld_d;
      sh_vld_q  <= sh_vld_d;
      done_o    <= done_d;
      if (cfg_we_i && cfg_idx_i == rtp_pkg::CfgBinWidth) begin
        bin_w_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == rtp_pkg::CfgBinHeight) begin
        bin_h_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_op_q <= opcode_i;
      req_w_q  <= rect_width_i;
      req_h_q  <= rect_height_i;
    end
    prod_q     <= rtp_pkg::AreaW'(req_w_q * req_h_q);
    iss_q      <= iss_d;
    src_q      <= src_d;
    chk_idx_q  <= chk_idx_d;
    sh_dst_q   <= sh_dst_d;
    hit_q      <= hit_d;
    hit_rect_q <= hit_rect_d;
    status_q   <= status_d;
    px_q       <= px_d;
    py_q       <= py_d;
  end

  assign status_o    = status_q;
  assign place_x_o   = px_q;
  assign place_y_o   = py_q;
  assign area_used_o = area_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= rtp_pkg::CntW'(rtp_pkg::MaxFree)))
    else $error("free count out of range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == rtp_pkg::StIdle))
    else $error("result word outside idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted op did not raise busy");

  a_shift_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sh_vld_q && state_q == rtp_pkg::StShift) |->
      (rtp_pkg::CntW'(sh_dst_q) > hit_next))
    else $error("shift overwrites the hit or its first child slot");

  a_place_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtp_pkg::StWriteB) |=> (count_q == $past(count_q) + rtp_pkg::CntW'(1)))
    else $error("placement did not grow the free list");

  a_op_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rtp_pkg::StClear) |-> (req_op_q == rtp_pkg::OpClear))
    else $error("clear path taken for an insert");

endmodule

>>> rtl/rtp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rtp_ram #(
  parameter int Width = 64,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/rtp_split.sv
// Guillotine split of a free rectangle around a placed request.
// Depends on rtp_pkg.
module rtp_split (
  input  rtp_pkg::rect_t                free_i,
  input  logic [rtp_pkg::CoordW-1:0]    rect_width_i,
  input  logic [rtp_pkg::CoordW-1:0]    rect_height_i,
  output rtp_pkg::rect_t                child_a_o,
  output rtp_pkg::rect_t                child_b_o
);

  logic [rtp_pkg::CoordW-1:0] wrem;
  logic [rtp_pkg::CoordW-1:0] hrem;
  logic [rtp_pkg::CoordW-1:0] x_right;
  logic [rtp_pkg::CoordW-1:0] y_top;

  assign wrem    = free_i.w - rect_width_i;
  assign hrem    = free_i.h - rect_height_i;
  assign x_right = free_i.x + rect_width_i;
  assign y_top   = free_i.y + rect_height_i;

  // cut along the shorter leftover
  always_comb begin
    if (wrem <= hrem) begin
      child_a_o = '{x: x_right, y: free_i.y, w: wrem, h: rect_height_i};
      child_b_o = '{x: free_i.x, y: y_top, w: free_i.w, h: hrem};
    end else begin
      child_a_o = '{x: free_i.x, y: y_top, w: rect_width_i, h: hrem};
      child_b_o = '{x: x_right, y: free_i.y, w: wrem, h: free_i.h};
    end
  end

endmodule
